// ----- rtl/keypad_code_lock_with_lockout_assert.svh -----
// ----------------------------------------------------------------------------
// keypad_code_lock_with_lockout_assert.svh
// assertion macros for the keypad code lock; empty bodies when SYNTH is set
// ----------------------------------------------------------------------------
`ifndef KEYPAD_CODE_LOCK_WITH_LOCKOUT_ASSERT_SVH
`define KEYPAD_CODE_LOCK_WITH_LOCKOUT_ASSERT_SVH

`ifndef SYNTH

// same-cycle implication
`define KCL_ASSERT_IMP(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error("kcl assertion failed");

// next-cycle implication
`define KCL_ASSERT_NXT(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error("kcl assertion failed");

`else

`define KCL_ASSERT_IMP(label, clk, rst_n, lhs, rhs)
`define KCL_ASSERT_NXT(label, clk, rst_n, lhs, rhs)

`endif

`endif

// ----- rtl/kcl_pkg.sv -----
// ----------------------------------------------------------------------------
// kcl_pkg
// types and constants shared by the keypad code lock modules
// ----------------------------------------------------------------------------
package kcl_pkg;

    // key codes
    localparam logic [7:0] KEY_D = 8'h44;
    localparam logic [7:0] KEY_A = 8'h41;
    localparam logic [7:0] KEY_0 = 8'h30;
    localparam logic [7:0] KEY_9 = 8'h39;

    // mode codes on the result
    localparam logic [1:0] MODE_UNLOCKED = 2'd0;
    localparam logic [1:0] MODE_LOCKED   = 2'd1;
    localparam logic [1:0] MODE_ENTERING = 2'd2;
    localparam logic [1:0] MODE_LOCKOUT  = 2'd3;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_CODE_DIGITS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOCKOUT_TICKS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLINK_TICKS   = 2'd2;
    localparam int CFG_DATA_W = 32;

    // configuration reset values
    localparam logic [31:0] CODE_RESET    = 32'h1234_5678;
    localparam logic [15:0] LOCKOUT_RESET = 16'd1000;
    localparam logic [15:0] BLINK_RESET   = 16'd20;

    typedef enum logic [3:0] {
        S_UNLOCKED = 4'b0001,
        S_LOCKED   = 4'b0010,
        S_ENTERING = 4'b0100,
        S_LOCKOUT  = 4'b1000
    } t_mode;

    typedef struct packed {
        logic [31:0] code_digits;
        logic [15:0] lockout_ticks;
        logic [15:0] blink_ticks;
    } t_cfg;

    typedef struct packed {
        logic [1:0] mode;
        logic       lock_led;
        logic       entry_led;
        logic [3:0] digits_entered;
    } t_result;

    function automatic logic [1:0] mode_code(input t_mode m);
        logic [1:0] c;
        unique case (m)
            S_UNLOCKED: c = MODE_UNLOCKED;
            S_LOCKED:   c = MODE_LOCKED;
            S_ENTERING: c = MODE_ENTERING;
            S_LOCKOUT:  c = MODE_LOCKOUT;
            default:    c = MODE_LOCKED;
        endcase
        return c;
    endfunction

endpackage

// ----- rtl/kcl_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// kcl_cfg_regs
// configuration registers: unlock code, lockout period, blink period
// ----------------------------------------------------------------------------
module kcl_cfg_regs
    import kcl_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_wr_en,
    input  logic [CFG_IDX_W-1:0] i_index,
    input  logic [CFG_DATA_W-1:0] i_wdata,
    output t_cfg                 o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.code_digits   <= CODE_RESET;
            r_cfg.lockout_ticks <= LOCKOUT_RESET;
            r_cfg.blink_ticks   <= BLINK_RESET;
        end else if (i_wr_en) begin
            unique case (i_index)
                CFG_CODE_DIGITS:   r_cfg.code_digits   <= i_wdata;
                CFG_LOCKOUT_TICKS: r_cfg.lockout_ticks <= i_wdata[15:0];
                CFG_BLINK_TICKS:   r_cfg.blink_ticks   <= i_wdata[15:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- rtl/kcl_in_stage.sv -----
// ----------------------------------------------------------------------------
// kcl_in_stage
// input register for key codes with valid/stall handshake
// ----------------------------------------------------------------------------
module kcl_in_stage
    import kcl_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_key_code,
    input  logic       i_out_ready,
    output logic       o_stall,
    output logic       o_step,
    output logic [7:0] o_key
);

    logic       r_valid;
    logic [7:0] r_key;
    logic       load;

    assign o_stall = r_valid && !i_out_ready;
    assign o_step  = r_valid && i_out_ready;
    assign load    = !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && i_valid) begin
            r_key <= i_key_code;
        end
    end

    assign o_key = r_key;

endmodule

// ----- rtl/kcl_core.sv -----
// ----------------------------------------------------------------------------
// kcl_core
// lock state machine, digit store, code compare and lockout timers
// ----------------------------------------------------------------------------
module kcl_core
    import kcl_pkg::*;
#(
    parameter int CODE_LEN = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic [7:0] i_key,
    input  t_cfg       i_cfg,
    output t_result    o_result
);

    localparam int CNT_W = $clog2(CODE_LEN + 1);

    t_mode            r_mode, n_mode;
    logic [CNT_W-1:0] r_entry_count, n_entry_count;
    logic [7:0]       r_prev_digit, n_prev_digit;
    logic [15:0]      r_lock_cnt, n_lock_cnt;
    logic [15:0]      r_blink_cnt, n_blink_cnt;
    logic             r_lock_led, n_lock_led;
    logic             r_entry_led, n_entry_led;
    logic [3:0]       r_store [CODE_LEN];

    logic                is_digit;
    logic                store_full;
    logic                take_digit;
    logic                store_wr;
    logic [CODE_LEN-1:0] digit_eq;
    logic                code_match;
    logic [16:0]         blink_inc;
    logic [16:0]         lock_inc;
    logic                blink_hit;
    logic                lock_hit;

    assign is_digit   = (i_key >= KEY_0) && (i_key <= KEY_9);
    assign store_full = (r_entry_count == CNT_W'(CODE_LEN));
    assign take_digit = is_digit && (i_key != r_prev_digit) && !store_full;

    // wanted digit per position; nibbles above bit 31 read as zero
    for (genvar gi = 0; gi < CODE_LEN; gi++) begin : g_cmp
        localparam int SH = CODE_LEN - 1 - gi;
        logic [3:0] want;
        if (SH < 8) begin : g_nib
            assign want = i_cfg.code_digits[SH*4 +: 4];
        end else begin : g_zero
            assign want = 4'd0;
        end
        assign digit_eq[gi] = (r_store[gi] == want);

        always_ff @(posedge i_clk) begin
            if (i_step && store_wr && (r_entry_count == CNT_W'(gi))) begin
                // ascii '0'..'9' carry the bcd digit in the low nibble
                r_store[gi] <= i_key[3:0];
            end
        end
    end

    assign code_match = store_full && (&digit_eq);

    assign blink_inc = {1'b0, r_blink_cnt} + 17'd1;
    assign lock_inc  = {1'b0, r_lock_cnt} + 17'd1;
    assign blink_hit = (blink_inc >= {1'b0, i_cfg.blink_ticks});
    assign lock_hit  = (lock_inc >= {1'b0, i_cfg.lockout_ticks});

    always_comb begin
        n_mode        = r_mode;
        n_entry_count = r_entry_count;
        n_prev_digit  = r_prev_digit;
        n_lock_cnt    = r_lock_cnt;
        n_blink_cnt   = r_blink_cnt;
        n_lock_led    = r_lock_led;
        n_entry_led   = r_entry_led;
        store_wr      = 1'b0;
        unique case (r_mode)
            S_LOCKED: begin
                if (i_key == KEY_D) begin
                    n_mode      = S_ENTERING;
                    n_entry_led = !r_entry_led;
                end
            end
            S_ENTERING: begin
                if (is_digit) begin
                    if (take_digit) begin
                        store_wr      = 1'b1;
                        n_entry_count = r_entry_count + CNT_W'(1);
                        n_entry_led   = !r_entry_led;
                        n_prev_digit  = i_key;
                    end
                end else if (i_key == KEY_A) begin
                    if (code_match) begin
                        n_mode     = S_UNLOCKED;
                        n_lock_led = 1'b0;
                    end else begin
                        n_mode        = S_LOCKOUT;
                        n_entry_count = '0;
                    end
                    n_entry_led = !r_entry_led;
                end
            end
            S_LOCKOUT: begin
                if (blink_hit) begin
                    n_blink_cnt = '0;
                    n_lock_led  = !r_lock_led;
                end else begin
                    n_blink_cnt = blink_inc[15:0];
                end
                if (lock_hit) begin
                    n_lock_cnt  = '0;
                    n_mode      = S_LOCKED;
                    n_lock_led  = 1'b1;
                    n_entry_led = 1'b1;
                end else begin
                    n_lock_cnt = lock_inc[15:0];
                end
            end
            S_UNLOCKED: ;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= S_LOCKED;
            r_entry_count <= '0;
            r_prev_digit  <= '0;
            r_lock_cnt    <= '0;
            r_blink_cnt   <= '0;
            r_lock_led    <= 1'b1;
            r_entry_led   <= 1'b1;
        end else if (i_step) begin
            r_mode        <= n_mode;
            r_entry_count <= n_entry_count;
            r_prev_digit  <= n_prev_digit;
            r_lock_cnt    <= n_lock_cnt;
            r_blink_cnt   <= n_blink_cnt;
            r_lock_led    <= n_lock_led;
            r_entry_led   <= n_entry_led;
        end
    end

    assign o_result.mode      = mode_code(n_mode);
    assign o_result.lock_led  = n_lock_led;
    assign o_result.entry_led = n_entry_led;

    if (CNT_W >= 4) begin : g_cnt_wide
        assign o_result.digits_entered = n_entry_count[3:0];
    end else begin : g_cnt_narrow
        assign o_result.digits_entered = {{(4 - CNT_W){1'b0}}, n_entry_count};
    end

endmodule

// ----- rtl/kcl_out_stage.sv -----
// ----------------------------------------------------------------------------
// kcl_out_stage
// result register with valid/stall handshake
// ----------------------------------------------------------------------------
module kcl_out_stage
    import kcl_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_result,
    input  logic    i_stall,
    output logic    o_ready,
    output logic    o_valid,
    output t_result o_result
);

    logic    r_valid;
    t_result r_result;

    assign o_ready = !r_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

// ----- rtl/keypad_code_lock_with_lockout.sv -----
// a key code is registered in the input stage, and its result in the output stage
// throughput: one key code per cycle while the result is not stalled; the lock state updates in a single register loop
// a stalled result holds the core; input and output registers keep the pipeline full
// reset: synchronous, active low; locked mode, both leds lit, count cleared,
// configuration back to its defaults
// ----------------------------------------------------------------------------
// keypad_code_lock_with_lockout
// keypad combination lock with repeat suppression and timed lockout
// ----------------------------------------------------------------------------
`include "keypad_code_lock_with_lockout_assert.svh"

module keypad_code_lock_with_lockout
    import kcl_pkg::*;
#(
    parameter int CODE_LEN = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [7:0]            i_key_code,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [1:0]            o_mode,
    output logic                  o_lock_led,
    output logic                  o_entry_led,
    output logic [3:0]            o_digits_entered
);

    t_cfg       cfg;
    logic       out_ready;
    logic       step;
    logic [7:0] key;
    t_result    core_result;
    t_result    out_result;
    logic       out_unlocked;
    logic       out_lockout;
    logic       led_dark;

    kcl_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr_en (i_cfg_wr_en),
        .i_index (i_cfg_index),
        .i_wdata (i_cfg_wdata),
        .o_cfg   (cfg)
    );

    kcl_in_stage u_in (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in_valid),
        .i_key_code  (i_key_code),
        .i_out_ready (out_ready),
        .o_stall     (o_in_stall),
        .o_step      (step),
        .o_key       (key)
    );

    kcl_core #(
        .CODE_LEN (CODE_LEN)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_key    (key),
        .i_cfg    (cfg),
        .o_result (core_result)
    );

    kcl_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (step),
        .i_result (core_result),
        .i_stall  (i_out_stall),
        .o_ready  (out_ready),
        .o_valid  (o_out_valid),
        .o_result (out_result)
    );

    assign o_mode           = out_result.mode;
    assign o_lock_led       = out_result.lock_led;
    assign o_entry_led      = out_result.entry_led;
    assign o_digits_entered = out_result.digits_entered;

    assign out_unlocked = o_out_valid && (o_mode == MODE_UNLOCKED);
    assign out_lockout  = o_out_valid && (o_mode == MODE_LOCKOUT);
    assign led_dark     = o_out_valid && !o_lock_led;

    // unlocked is terminal: every later result stays unlocked
    `KCL_ASSERT_NXT(a_unlock_terminal, i_clk, i_rst_n, out_unlocked, !o_out_valid || out_unlocked)
    // the lock led is dark only while unlocked or blinking in lockout
    `KCL_ASSERT_IMP(a_led_dark_mode, i_clk, i_rst_n, led_dark, out_unlocked || out_lockout)
    // input backpressure only comes from a full, stalled result register
    `KCL_ASSERT_IMP(a_stall_source, i_clk, i_rst_n, o_in_stall, o_out_valid && i_out_stall)

endmodule

// ----- tb/sv/keypad_code_lock_with_lockout_test.sv -----
// ----------------------------------------------------------------------------
// keypad_code_lock_with_lockout_test
// drives key codes through the lock with random gaps and output stalls, keeps
// a cycle-free model of the lock state and compares every status transaction
// ----------------------------------------------------------------------------
module keypad_code_lock_with_lockout_test;
    timeunit 1ns;
    timeprecision 1ps;

    import kcl_pkg::*;

    localparam int CODE_LEN      = 8;
    localparam int ITEM_BUDGET   = 900;
    localparam int SETTLE_CYCLES = 4;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    class lock_scoreboard;
        logic [31:0] code_digits;
        logic [15:0] lockout_ticks;
        logic [15:0] blink_ticks;
        logic [1:0]  lock_mode;
        logic [3:0]  digit_store [CODE_LEN];
        logic [4:0]  entry_count;
        logic [7:0]  previous_digit;
        logic [16:0] lockout_count;
        logic [16:0] blink_count;
        logic        lock_led;
        logic        entry_led;
        t_result     expected_status [$];
        int          errors;

        function new();
            code_digits    = CODE_RESET;
            lockout_ticks  = LOCKOUT_RESET;
            blink_ticks    = BLINK_RESET;
            lock_mode      = MODE_LOCKED;
            foreach (digit_store[i]) digit_store[i] = '0;
            entry_count    = '0;
            previous_digit = '0;
            lockout_count  = '0;
            blink_count    = '0;
            lock_led       = 1'b1;
            entry_led      = 1'b1;
            errors         = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_CODE_DIGITS:   code_digits   = data[31:0];
                CFG_LOCKOUT_TICKS: lockout_ticks = data[15:0];
                CFG_BLINK_TICKS:   blink_ticks   = data[15:0];
                default: ;
            endcase
        endfunction

        function bit code_matches();
            int sh;
            logic [3:0] want;
            if (entry_count != CODE_LEN) return 1'b0;
            for (int i = 0; i < CODE_LEN; i++) begin
                sh = (CODE_LEN - 1 - i) * 4;
                want = (sh < 32) ? code_digits[sh +: 4] : 4'd0;
                if (digit_store[i] != want) return 1'b0;
            end
            return 1'b1;
        endfunction

        // advances the lock by one key and queues the status it must report
        function void note_key(logic [7:0] key);
            t_result status;
            case (lock_mode)
                MODE_LOCKED: begin
                    if (key == KEY_D) begin
                        lock_mode = MODE_ENTERING;
                        entry_led = ~entry_led;
                    end
                end
                MODE_ENTERING: begin
                    if (key >= KEY_0 && key <= KEY_9) begin
                        if (key != previous_digit && entry_count < CODE_LEN) begin
                            digit_store[entry_count] = 4'(key - KEY_0);
                            entry_count    = entry_count + 1'b1;
                            entry_led      = ~entry_led;
                            previous_digit = key;
                        end
                    end else if (key == KEY_A) begin
                        if (code_matches()) begin
                            lock_mode = MODE_UNLOCKED;
                            lock_led  = 1'b0;
                        end else begin
                            lock_mode   = MODE_LOCKOUT;
                            entry_count = '0;
                        end
                        entry_led = ~entry_led;
                    end
                end
                MODE_LOCKOUT: begin
                    blink_count = blink_count + 1'b1;
                    if (blink_count >= blink_ticks) begin
                        lock_led    = ~lock_led;
                        blink_count = '0;
                    end
                    lockout_count = lockout_count + 1'b1;
                    if (lockout_count >= lockout_ticks) begin
                        foreach (digit_store[i]) digit_store[i] = '0;
                        lock_mode     = MODE_LOCKED;
                        lock_led      = 1'b1;
                        entry_led     = 1'b1;
                        lockout_count = '0;
                    end
                end
                default: ;
            endcase
            status.mode           = lock_mode;
            status.lock_led       = lock_led;
            status.entry_led      = entry_led;
            status.digits_entered = entry_count[3:0];
            expected_status.push_back(status);
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (expected_status.size() == 0) begin
                $error("status transaction with none pending: mode %0d", got.mode);
                errors++;
                return;
            end
            want = expected_status.pop_front();
            if (got.mode !== want.mode) begin
                $error("mode: expected %0d, got %0d", want.mode, got.mode);
                errors++;
            end
            if (got.lock_led !== want.lock_led) begin
                $error("lock_led: expected %0d, got %0d", want.lock_led, got.lock_led);
                errors++;
            end
            if (got.entry_led !== want.entry_led) begin
                $error("entry_led: expected %0d, got %0d", want.entry_led, got.entry_led);
                errors++;
            end
            if (got.digits_entered !== want.digits_entered) begin
                $error("digits_entered: expected %0d, got %0d",
                       want.digits_entered, got.digits_entered);
                errors++;
            end
        endfunction

        function int pending();
            return expected_status.size();
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_wr_en;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic [7:0]            i_key_code;
    logic                  o_out_valid;
    logic                  i_out_stall;
    logic [1:0]            o_mode;
    logic                  o_lock_led;
    logic                  o_entry_led;
    logic [3:0]            o_digits_entered;

    lock_scoreboard sb = new();
    int  counted = 0;
    bit  sender_calm = 1'b0;
    int  stall_hold = 0;

    keypad_code_lock_with_lockout #(
        .CODE_LEN(CODE_LEN)
    ) i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_key_code       (i_key_code),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_mode           (o_mode),
        .o_lock_led       (o_lock_led),
        .o_entry_led      (o_entry_led),
        .o_digits_entered (o_digits_entered)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // receiver: quiet stretches, short stalls, now and then a long one
    always @(posedge i_clk) begin
        int r;
        if (stall_hold > 0) begin
            stall_hold <= stall_hold - 1;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 5) begin
                i_out_stall <= 1'b0;
                stall_hold  <= $urandom_range(50, 200);
            end else if (r < 10) begin
                i_out_stall <= 1'b1;
                stall_hold  <= $urandom_range(10, 40);
            end else if (r < 40) begin
                i_out_stall <= 1'b1;
                stall_hold  <= $urandom_range(0, 3);
            end else begin
                i_out_stall <= 1'b0;
                stall_hold  <= $urandom_range(0, 2);
            end
        end
    end

    always @(posedge i_clk) begin
        t_result seen;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            seen.mode           = o_mode;
            seen.lock_led       = o_lock_led;
            seen.entry_led      = o_entry_led;
            seen.digits_entered = o_digits_entered;
            sb.check_result(seen);
        end
    end

    function automatic int next_gap();
        int r;
        if (sender_calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // anything that is neither a digit nor the check key
    function automatic logic [7:0] noise_key();
        logic [7:0] k;
        do k = 8'($urandom_range(0, 255));
        while ((k >= KEY_0 && k <= KEY_9) || k == KEY_A);
        return k;
    endfunction

    // valid stays high into the next call when no gap is drawn
    task automatic send_key(input logic [7:0] key);
        int gap;
        i_in_valid <= 1'b1;
        i_key_code <= key;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_key(key);
        counted++;
        gap = next_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        while (sb.pending() > 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        sb.write_reg(idx, data);
        i_cfg_wr_en <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic configure(input logic [31:0] code, input logic [15:0] lockout,
                             input logic [15:0] blink);
        settle();
        write_reg(CFG_CODE_DIGITS, code);
        write_reg(CFG_LOCKOUT_TICKS, 32'(lockout));
        write_reg(CFG_BLINK_TICKS, 32'(blink));
    endtask

    task automatic ride_out_lockout();
        while (sb.lock_mode == MODE_LOCKOUT) send_key(8'($urandom_range(0, 255)));
    endtask

    // full-length entry of a code, optionally with one digit wrong; messy adds
    // ignored keys and suppressed repeats between the digits
    task automatic try_code(input logic [31:0] code, input bit near_miss, input bit messy);
        int bad_pos;
        int d;
        logic [7:0] key;
        bad_pos = near_miss ? int'($urandom_range(0, CODE_LEN - 1)) : -1;
        send_key(KEY_D);
        for (int i = 0; i < CODE_LEN; i++) begin
            d = int'(code[(CODE_LEN - 1 - i) * 4 +: 4]);
            if (i == bad_pos) d = (d + $urandom_range(1, 9)) % 10;
            key = 8'(KEY_0 + d);
            if (messy && $urandom_range(0, 3) == 0) send_key(noise_key());
            send_key(key);
            if (messy && $urandom_range(0, 4) == 0) send_key(key);
        end
        if (near_miss && messy && $urandom_range(0, 2) == 0)
            send_key(8'(KEY_0 + $urandom_range(0, 9)));
        send_key(KEY_A);
    endtask

    task automatic random_entry();
        int n;
        int d;
        d = $urandom_range(0, 9);
        n = $urandom_range(0, CODE_LEN + 2);
        send_key(KEY_D);
        repeat (n) begin
            if ($urandom_range(0, 9) < 7) d = $urandom_range(0, 9);
            if ($urandom_range(0, 5) == 0) send_key(noise_key());
            send_key(8'(KEY_0 + d));
        end
        send_key(KEY_A);
    endtask

    initial begin
        #20_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        int r;
        int round_left;
        int last;
        int d;
        logic [31:0] code;

        i_rst_n     <= 1'b0;
        i_cfg_wr_en <= 1'b0;
        i_cfg_index <= CFG_CODE_DIGITS;
        i_cfg_wdata <= '0;
        i_in_valid  <= 1'b0;
        i_key_code  <= '0;
        i_out_stall <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // keys ignored while locked, then a short entry with a repeat
        send_key(KEY_A);
        send_key(8'h00);
        send_key(8'hFF);
        send_key(KEY_0);
        send_key(KEY_D);
        send_key(KEY_D);
        send_key(KEY_0 + 8'd1);
        send_key(KEY_0 + 8'd1);
        send_key(KEY_0 + 8'd2);
        send_key(8'h80);
        send_key(KEY_0 + 8'd3);
        send_key(KEY_A);
        repeat (60) send_key(8'($urandom_range(0, 255)));
        settle();
        write_reg(CFG_BLINK_TICKS, '0);
        repeat (40) send_key(8'($urandom_range(0, 255)));
        // lockout period dropped below the running count
        settle();
        write_reg(CFG_LOCKOUT_TICKS, 32'd5);
        ride_out_lockout();

        // last digit wrong, extra digit on a full store
        send_key(KEY_D);
        for (d = 1; d <= 7; d++) send_key(8'(KEY_0 + d));
        send_key(KEY_9);
        send_key(KEY_0 + 8'd5);
        send_key(KEY_A);
        ride_out_lockout();

        // last digit survives relock, so it is still suppressed
        send_key(KEY_D);
        send_key(KEY_9);
        send_key(KEY_A);
        ride_out_lockout();

        configure(32'h12A4_5678, 16'd1, 16'd1);
        try_code(32'h12A4_5678, 1'b0, 1'b0);
        ride_out_lockout();
        configure(32'h9999_9999, 16'd0, 16'hFFFF);
        try_code(32'h9999_9999, 1'b0, 1'b1);
        ride_out_lockout();
        configure(32'h0000_0000, 16'd45, 16'd7);
        random_entry();
        ride_out_lockout();
        settle();
        write_reg(CFG_UNUSED, $urandom());
        configure(32'h8765_4321, 16'd50, 16'hFFFF);
        sender_calm = 1'b1;
        random_entry();
        ride_out_lockout();
        sender_calm = 1'b0;

        round_left = 0;
        while (counted < ITEM_BUDGET) begin
            if (round_left == 0) begin
                ride_out_lockout();
                if ($urandom_range(0, 3) == 0) begin
                    code = $urandom_range(0, 32'h9999_9999);
                end else begin
                    for (int i = 0; i < 8; i++) code[i * 4 +: 4] = 4'($urandom_range(0, 9));
                end
                r = $urandom_range(0, 99);
                configure(code,
                          (r < 10) ? 16'd0 : (r < 20) ? 16'd1 : 16'($urandom_range(2, 40)),
                          ($urandom_range(0, 99) < 15) ? 16'($urandom_range(0, 1))
                                                       : 16'($urandom_range(2, 12)));
                if ($urandom_range(0, 7) == 0) write_reg(CFG_UNUSED, $urandom());
                sender_calm = ($urandom_range(0, 3) == 0);
                round_left  = $urandom_range(4, 10);
            end
            ride_out_lockout();
            if ($urandom_range(0, 9) == 0) repeat ($urandom_range(1, 4)) send_key(noise_key());
            r = $urandom_range(0, 99);
            if (r < 45) begin
                try_code(sb.code_digits, 1'b1, 1'($urandom_range(0, 1)));
            end else if (r < 85) begin
                random_entry();
            end else begin
                send_key(KEY_D);
                repeat ($urandom_range(0, 6)) send_key(noise_key());
                send_key(KEY_A);
            end
            round_left--;
        end

        // one correct entry: no adjacent repeats, first digit differs from the last stored
        ride_out_lockout();
        last = int'(sb.previous_digit) - int'(KEY_0);
        for (int i = CODE_LEN - 1; i >= 0; i--) begin
            do d = $urandom_range(0, 9); while (d == last);
            code[i * 4 +: 4] = 4'(d);
            last = d;
        end
        configure(code, 16'($urandom_range(1, 40)), 16'($urandom_range(1, 10)));
        sender_calm = 1'b0;
        try_code(code, 1'b0, 1'b1);
        // unlocked holds whatever comes in
        repeat (30) begin
            r = $urandom_range(0, 3);
            send_key((r == 0) ? KEY_D : (r == 1) ? KEY_A :
                     (r == 2) ? 8'(KEY_0 + $urandom_range(0, 9)) : 8'($urandom_range(0, 255)));
        end

        i_in_valid <= 1'b0;
        for (int n = 0; n < 10000 && sb.pending() > 0; n++) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (sb.pending() != 0) $error("%0d status transactions never arrived", sb.pending());
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
